// ===== hdl/dabc_pkg.sv =====
`timescale 1ns / 1ps
package dabc_pkg;
  localparam int unsigned DefEntries  = 512;
  localparam int unsigned DefMacBytes = 7;
  localparam int unsigned MacW        = 56;
  localparam int unsigned DevW        = 22;
  localparam logic [21:0] InvalidDevice = 22'h3FFFFF;
  localparam logic [15:0] BroadcastNet  = 16'hFFFF;
  localparam logic [31:0] TtlReset      = 32'd300;
  localparam logic [9:0]  MaxDynReset   = 10'd512;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpLookId = 2'd1;
  localparam logic [1:0] OpLookAd = 2'd2;
  localparam logic [1:0] OpDelete = 2'd3;

  localparam logic [1:0] StHit    = 2'd0;
  localparam logic [1:0] StMiss   = 2'd1;
  localparam logic [1:0] StReject = 2'd2;
  localparam logic [1:0] StFull   = 2'd3;

  localparam logic [1:0] CfgTtl    = 2'd0;
  localparam logic [1:0] CfgMaxDyn = 2'd1;
  localparam logic [1:0] CfgOwnId  = 2'd2;

  typedef struct packed {
    logic        valid;
    logic        pinned;
    logic [21:0] device;
    logic [15:0] net;
    logic [2:0]  mac_length;
    logic [55:0] mac;
    logic [15:0] apdu;
    logic [31:0] stamp;
    logic [31:0] recency;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);
endpackage

// ===== hdl/dabc_ram.sv =====
`timescale 1ns / 1ps
module dabc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/device_address_binding_cache_unit.sv =====
`timescale 1ns / 1ps
// Operation: each scans every slot through the registered-read memory, then writes back;
//   the result strobe is registered in the main write-back state (S_DONE).
// Throughput: one operation at a time (a start is taken only while idle); an add that moves
//   an id onto an address held by another slot keeps busy high through an extra write state that clears that slot.
// Reset: asynchronous, active low; then busy stays high while a clear state writes every slot to zero.
// The result is shown for one cycle on done_o; the receiver cannot stall.
module device_address_binding_cache_unit
  import dabc_pkg::*;
#(
  parameter int unsigned Entries  = DefEntries,
  parameter int unsigned MacBytes = DefMacBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  opcode_i,
  input  logic [21:0] device_id_i,
  input  logic [15:0] max_apdu_i,
  input  logic [15:0] net_number_i,
  input  logic [2:0]  mac_length_i,
  input  logic [55:0] mac_bytes_i,
  input  logic        make_static_i,
  input  logic [31:0] now_seconds_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [21:0] found_device_o,
  output logic [15:0] found_max_apdu_o,
  output logic [15:0] found_net_o,
  output logic [2:0]  found_mac_length_o,
  output logic [55:0] found_mac_o,
  output logic        whois_request_o,
  output logic [15:0] whois_net_o
);
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RDA  = 3'd2;
  localparam logic [2:0] S_RDB  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;
  localparam logic [2:0] S_WR2  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [31:0] ttl_q;
  logic [9:0]  maxdyn_q;
  logic [21:0] own_q;
  logic [31:0] rec_q;
  logic [9:0]  dyn_q;

  logic [1:0]  op_q;
  logic [21:0] id_q;
  logic [15:0] apdu_q, net_q;
  logic [2:0]  len_q;
  logic [55:0] mac_q;
  logic        st_q;
  logic [31:0] now_q;

  logic [CntW-1:0] scan_q;
  logic            rd_v_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            d_f_q, a_f_q, fr_f_q, l_f_q;
  logic [IdxW-1:0] d_i_q, a_i_q, fr_i_q, l_i_q;
  logic [31:0]     l_age_q;
  slot_t           sd_q, sa_q;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t           wdata, rdata;

  dabc_ram #(.Width(SlotW), .Depth(Entries)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [2:0]  len_c;
  logic [55:0] mask_c, mac_c;
  always_comb begin
    len_c = (int'(mac_length_i) > MacBytes) ? 3'(MacBytes) : mac_length_i;
    mask_c = '0;
    for (int b = 0; b < 7; b++) if (b < int'(len_c)) mask_c[8*b +: 8] = 8'hFF;
    mac_c = mac_bytes_i & mask_c;
  end

  logic        rv, m_dev, m_adr;
  logic [31:0] age;
  assign rv    = rd_v_q && rdata.valid;
  assign m_dev = rdata.device == id_q;
  assign m_adr = rdata.net == net_q && rdata.mac_length == len_q && rdata.mac == mac_q;
  assign age   = rec_q - rdata.recency;

  assign raddr = (state_q == S_RDA) ? d_i_q : (state_q == S_RDB) ? a_i_q : scan_q[IdxW-1:0];

  // decision
  logic [31:0] rec_n;
  logic [9:0]  dyn_n;
  logic [1:0]  status_n;
  logic        wi_n, hit_n, wr2_n;
  logic [15:0] wn_n;
  slot_t       rep_n;
  logic [31:0] sage;
  logic        dlive;

  always_comb begin
    rec_n = rec_q; dyn_n = dyn_q;
    status_n = StMiss; wi_n = 1'b0; wn_n = '0; hit_n = 1'b0; rep_n = sd_q; wr2_n = 1'b0;
    we = 1'b0; waddr = d_i_q; wdata = sd_q;
    sage = now_q - sd_q.stamp;
    dlive = sd_q.pinned || sage < ttl_q;
    if (state_q == S_CLR) begin
      we = 1'b1; waddr = scan_q[IdxW-1:0]; wdata = '0;
    end else if (state_q == S_WR2) begin
      we = 1'b1; waddr = a_i_q; wdata = sa_q; wdata.valid = 1'b0;
    end else if (state_q == S_DONE) begin
      unique case (op_q)
        OpAdd: begin
          if (id_q == InvalidDevice) status_n = StReject;
          else begin
            status_n = StHit;
            if (!d_f_q) begin
              if (!a_f_q) begin
                if (dyn_q < maxdyn_q ? !fr_f_q : !l_f_q) status_n = StFull;
                else begin
                  waddr = (dyn_q < maxdyn_q) ? fr_i_q : l_i_q;
                  if (dyn_q >= maxdyn_q && dyn_n != 0) dyn_n = dyn_n - 1'b1;
                  wdata.valid = 1'b1;
                  wdata.device = id_q; wdata.net = net_q;
                  wdata.mac_length = len_q; wdata.mac = mac_q;
                end
              end else if (sa_q.pinned) status_n = StReject;
              else begin
                waddr = a_i_q; wdata = sa_q; wdata.device = id_q;
                if (dyn_n != 0) dyn_n = dyn_n - 1'b1;
              end
            end else if (sd_q.pinned) status_n = StReject;
            else if (sd_q.net == net_q && sd_q.mac_length == len_q && sd_q.mac == mac_q) begin
              if (dyn_n != 0) dyn_n = dyn_n - 1'b1;
            end else if (a_f_q && sa_q.pinned) status_n = StReject;
            else begin
              if (a_f_q) begin
                wr2_n = 1'b1;
                if (dyn_n != 0) dyn_n = dyn_n - 1'b1;
              end
              wdata.net = net_q; wdata.mac_length = len_q; wdata.mac = mac_q;
              if (dyn_n != 0) dyn_n = dyn_n - 1'b1;
            end
            if (status_n == StHit) begin
              we = 1'b1;
              wdata.pinned = st_q; wdata.apdu = apdu_q;
              if (!st_q) begin
                wdata.stamp = now_q;
                rec_n = rec_q + 1'b1; wdata.recency = rec_n;
                dyn_n = dyn_n + 1'b1;
              end
            end
          end
        end
        OpLookId: begin
          if (id_q == InvalidDevice || id_q == own_q) status_n = StReject;
          else if (!d_f_q) begin wi_n = 1'b1; wn_n = BroadcastNet; end
          else if (dlive) begin
            status_n = StHit; hit_n = 1'b1;
            if (!sd_q.pinned) begin
              rec_n = rec_q + 1'b1; we = 1'b1; wdata.recency = rec_n;
              if (sage > (ttl_q >> 1)) begin wi_n = 1'b1; wn_n = sd_q.net; end
            end
          end else begin
            wi_n = 1'b1; wn_n = sd_q.net;
            we = 1'b1; wdata.valid = 1'b0;
            if (dyn_n != 0) dyn_n = dyn_n - 1'b1;
          end
        end
        OpLookAd: begin
          if (a_f_q) begin
            rep_n = sa_q;
            sage = now_q - sa_q.stamp;
            waddr = a_i_q; wdata = sa_q;
            if (sa_q.pinned || sage < ttl_q) begin
              status_n = StHit; hit_n = 1'b1;
              if (!sa_q.pinned) begin
                rec_n = rec_q + 1'b1; we = 1'b1; wdata.recency = rec_n;
              end
            end else begin
              we = 1'b1; wdata.valid = 1'b0;
              if (dyn_n != 0) dyn_n = dyn_n - 1'b1;
            end
          end
        end
        default: begin
          if (id_q == InvalidDevice) status_n = StReject;
          else if (d_f_q) begin
            status_n = StHit; we = 1'b1; wdata.valid = 1'b0;
            if (!sd_q.pinned && dyn_n != 0) dyn_n = dyn_n - 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_SCAN;
      S_SCAN: if (scan_q == CntW'(Entries)) state_d = S_RDA;
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_DEC;
      S_DEC:  state_d = S_DONE;
      S_DONE: state_d = wr2_n ? S_WR2 : S_IDLE;
      S_CLR:  if (scan_q == CntW'(Entries - 1)) state_d = S_IDLE;
      S_WR2:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; ttl_q <= TtlReset; maxdyn_q <= MaxDynReset;
      own_q <= InvalidDevice; rec_q <= '0; dyn_q <= '0;
      op_q <= '0; id_q <= '0; apdu_q <= '0; net_q <= '0; len_q <= '0; mac_q <= '0;
      st_q <= 1'b0; now_q <= '0; sd_q <= '0; sa_q <= '0;
      scan_q <= '0; rd_v_q <= 1'b0; rd_idx_q <= '0;
      d_f_q <= 1'b0; a_f_q <= 1'b0; fr_f_q <= 1'b0; l_f_q <= 1'b0;
      d_i_q <= '0; a_i_q <= '0; fr_i_q <= '0; l_i_q <= '0; l_age_q <= '0;
      done_o <= 1'b0; status_o <= '0; whois_request_o <= 1'b0; whois_net_o <= '0;
      found_device_o <= '0; found_max_apdu_o <= '0; found_net_o <= '0;
      found_mac_length_o <= '0; found_mac_o <= '0;
    end else begin
      state_q <= state_d;
      done_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgTtl:    ttl_q <= cfg_data_i;
          CfgMaxDyn: maxdyn_q <= cfg_data_i[9:0];
          CfgOwnId:  own_q <= cfg_data_i[21:0];
          default: ;
        endcase
      end
      if (state_q == S_CLR) scan_q <= scan_q + 1'b1;
      if (state_q == S_IDLE && start) begin
        op_q <= opcode_i; id_q <= device_id_i; apdu_q <= max_apdu_i;
        net_q <= net_number_i; len_q <= len_c; mac_q <= mac_c;
        st_q <= make_static_i; now_q <= now_seconds_i;
        scan_q <= '0; rd_v_q <= 1'b0;
        d_f_q <= 1'b0; a_f_q <= 1'b0; fr_f_q <= 1'b0; l_f_q <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        rd_v_q <= scan_q != CntW'(Entries);
        rd_idx_q <= scan_q[IdxW-1:0];
        if (scan_q != CntW'(Entries)) scan_q <= scan_q + 1'b1;
        if (rd_v_q) begin
          if (!rdata.valid && !fr_f_q) begin fr_f_q <= 1'b1; fr_i_q <= rd_idx_q; end
          if (rv && m_dev && !d_f_q) begin d_f_q <= 1'b1; d_i_q <= rd_idx_q; end
          if (rv && m_adr && !a_f_q) begin a_f_q <= 1'b1; a_i_q <= rd_idx_q; end
          if (rv && !rdata.pinned && (!l_f_q || age > l_age_q)) begin
            l_f_q <= 1'b1; l_i_q <= rd_idx_q; l_age_q <= age;
          end
        end
      end
      if (state_q == S_RDB) sd_q <= rdata;
      if (state_q == S_DEC) sa_q <= rdata;
      if (state_q == S_DONE) begin
        rec_q <= rec_n; dyn_q <= dyn_n;
        done_o <= 1'b1; status_o <= status_n;
        whois_request_o <= wi_n; whois_net_o <= wn_n;
        found_device_o <= hit_n ? rep_n.device : '0;
        found_max_apdu_o <= hit_n ? rep_n.apdu : '0;
        found_net_o <= hit_n ? rep_n.net : '0;
        found_mac_length_o <= hit_n ? rep_n.mac_length : '0;
        found_mac_o <= hit_n ? rep_n.mac : '0;
      end
    end
  end
endmodule

// ===== hdl/dabc_checker.sv =====
`timescale 1ns / 1ps
module dabc_checker
  import dabc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic       whois_request_o,
  input logic [15:0] whois_net_o,
  input logic [21:0] found_device_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("strobe without work");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("strobe held");
  a_whois_net: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !whois_request_o |-> whois_net_o == '0) else $error("stray who-is net");
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StHit |-> found_device_o == '0) else $error("stray found data");
endmodule

bind device_address_binding_cache_unit dabc_checker u_dabc_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o,
  .whois_request_o, .whois_net_o, .found_device_o
);
